// ----- design/etcd_pkg.sv -----
// ----------------------------------------------------------------------------
// etcd_pkg
// Types and constants shared by the epoch to calendar date conversion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etcd_pkg;

   localparam int EPOCH_BITS  = 34;
   localparam int MILLIS_BITS = 10;

   localparam int EPOCH_2001_SECS = 978307200;
   localparam int SECS_PER_DAY    = 86400;
   localparam int SECS_PER_HOUR   = 3600;
   localparam int SECS_PER_MIN    = 60;
   localparam int DAYS_400Y       = 146097;
   localparam int DAYS_100Y       = 36524;
   localparam int DAYS_4Y         = 1461;
   localparam int DAYS_1Y         = 365;
   localparam int DAYS_PER_WEEK   = 7;

   localparam logic [11:0] YEAR_BASE = 12'd2001;

   // register select, taken from address bit 2
   localparam logic REG_USE_LOCAL = 1'b0;
   localparam logic REG_OFFSET    = 1'b1;

   typedef struct packed {
      logic [EPOCH_BITS-1:0]  epoch_seconds;
      logic [MILLIS_BITS-1:0] millis_in;
   } req_type;

   typedef struct packed {
      logic [11:0]            year;
      logic [3:0]             month;
      logic [4:0]             day_of_month;
      logic [4:0]             hour;
      logic [5:0]             minute;
      logic [5:0]             second;
      logic [MILLIS_BITS-1:0] millis_out;
      logic [2:0]             weekday;
      logic                   before_epoch;
   } rsp_type;

   // day of year (from 0) on which month idx+1 starts, non-leap year
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] v;
      case (idx)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd59;
         4'd3:    v = 9'd90;
         4'd4:    v = 9'd120;
         4'd5:    v = 9'd151;
         4'd6:    v = 9'd181;
         4'd7:    v = 9'd212;
         4'd8:    v = 9'd243;
         4'd9:    v = 9'd273;
         4'd10:   v = 9'd304;
         4'd11:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- design/etcd_recip.sv -----
// ----------------------------------------------------------------------------
// etcd_recip
// Unsigned division by a constant through a rounded-up reciprocal multiply;
// exact for every XW-bit dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etcd_recip #(
   parameter int XW  = 16,
   parameter int DIV = 3,
   parameter int QW  = 15
) (
   input  logic [XW-1:0] x,
   output logic [QW-1:0] q
);

   localparam int LW = $clog2(DIV);
   localparam int SH = XW + LW;
   localparam int PW = SH + QW;
   localparam logic [63:0] MUL64 = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

   logic [PW-1:0] prod;

   assign prod = PW'(x) * PW'(MUL64);
   assign q    = prod[PW-1:SH];

endmodule

`default_nettype wire

// ----- design/epoch_to_calendar_date_unit.sv -----
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_unit
// 12 register stages: stage 0 registers the request, stage 1 adds the local
// offset and subtracts the 2001 epoch, stages 2 to 10 do constant-reciprocal
// multiplies and multiply-subtracts, and stage 11 finds month and day.
// Throughput: one beat per cycle while rsp_ready is high; each of the 12
// pipeline stages holds its own beat and moves on once the next stage frees up.
// Reset clears all stage valids and the configuration registers (UTC, offset 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epoch_to_calendar_date_unit #(
   parameter int SECONDS_BITS = 34
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  etcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output etcd_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int NSTG = 12;
   localparam int LAST = NSTG - 1;
   localparam int UB   = (SECONDS_BITS < etcd_pkg::EPOCH_BITS) ? SECONDS_BITS
                                                               : etcd_pkg::EPOCH_BITS;
   localparam int TB   = UB + 1;
   localparam int XB   = TB - 7;
   localparam logic [63:0] DMAX    = ((64'd1 << TB) - 64'd1) / 64'(etcd_pkg::SECS_PER_DAY);
   localparam int DB               = $clog2(DMAX + 64'd1);
   localparam logic [63:0] Q400MAX = DMAX / 64'(etcd_pkg::DAYS_400Y);
   localparam int Q400B            = (Q400MAX > 64'd0) ? $clog2(Q400MAX + 64'd1) : 1;
   localparam int WB               = (DB > 18) ? DB : 18;
   localparam int W7B              = DB - 2;

   // configuration
   logic        use_local_ff;
   logic [10:0] offset_ff;

   // handshake
   logic [LAST:0] vld_ff;
   logic [LAST:0] adv;

   // carried fields
   logic [9:0]  ms_ff  [0:10];
   logic        bef_ff [1:10];
   logic [11:0] yr_ff  [4:10];
   logic [4:0]  hr_ff  [4:10];
   logic [2:0]  wd_ff  [4:10];
   logic [5:0]  mn_ff  [6:10];
   logic [5:0]  sec_ff [7:10];

   // stage registers
   logic [UB-1:0]    sec0_ff;
   logic [TB-1:0]    t1_ff, t2_ff;
   logic [DB-1:0]    d2_ff, d3_ff;
   logic [16:0]      sod3_ff, sod4_ff;
   logic [Q400B-1:0] q400_3_ff;
   logic [W7B-1:0]   wq3_ff;
   logic [17:0]      r400_4_ff, r400_5_ff;
   logic [1:0]       q100_5_ff, q100_6_ff, q100_7_ff;
   logic [11:0]      rem5_ff, rem6_ff;
   logic [15:0]      r100_6_ff, r100_7_ff;
   logic [4:0]       q4_7_ff;
   logic [10:0]      r4_8_ff, r4_9_ff;
   logic             lc8_ff, lc9_ff;
   logic [1:0]       q1_9_ff;
   logic [8:0]       r1_10_ff;
   logic             leap10_ff;
   etcd_pkg::rsp_type out_ff;

   // combinational
   logic [16:0]      offs_sec;
   logic [UB+1:0]    adj_s, diff_s;
   logic [DB-1:0]    day_q;
   logic [Q400B-1:0] c400_q;
   logic [W7B-1:0]   wk_q;
   logic [TB-1:0]    sod_full;
   logic [WB-1:0]    r400_full;
   logic [DB-1:0]    wd_full;
   logic [4:0]       hr_q;
   logic [2:0]       q100_raw;
   logic [1:0]       q100_c;
   logic [16:0]      rem_full;
   logic [17:0]      r100_full;
   logic [5:0]       mn_q;
   logic [4:0]       c4_q;
   logic [11:0]      sec_full;
   logic [15:0]      r4_full;
   logic [2:0]       q1_raw;
   logic [1:0]       q1_c;
   logic [10:0]      r1_full;
   etcd_pkg::rsp_type out_in;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_local_ff <= 1'b0;
         offset_ff    <= 11'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[2])
            etcd_pkg::REG_USE_LOCAL: use_local_ff <= csr_pwdata[0];
            etcd_pkg::REG_OFFSET:    offset_ff    <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         etcd_pkg::REG_USE_LOCAL: csr_prdata = {31'd0, use_local_ff};
         etcd_pkg::REG_OFFSET:    csr_prdata = {21'd0, offset_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline control ----------------
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k <= LAST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------- datapath ----------------
   assign offs_sec = {{6{offset_ff[10]}}, offset_ff} * 17'd60;
   assign adj_s    = {2'b00, sec0_ff} +
                     (use_local_ff ? {{(UB - 15){offs_sec[16]}}, offs_sec} : '0);
   assign diff_s   = adj_s - (UB + 2)'(etcd_pkg::EPOCH_2001_SECS);

   etcd_recip #(.XW(XB), .DIV(675), .QW(DB)) u_day (
      .x (t1_ff[TB-1:7]),
      .q (day_q)
   );

   etcd_recip #(.XW(DB), .DIV(etcd_pkg::DAYS_400Y), .QW(Q400B)) u_c400 (
      .x (d2_ff),
      .q (c400_q)
   );

   etcd_recip #(.XW(DB), .DIV(etcd_pkg::DAYS_PER_WEEK), .QW(W7B)) u_wk (
      .x (d2_ff),
      .q (wk_q)
   );

   assign sod_full  = t2_ff - TB'(d2_ff) * TB'(etcd_pkg::SECS_PER_DAY);
   assign r400_full = WB'(d3_ff) - WB'(q400_3_ff) * WB'(etcd_pkg::DAYS_400Y);
   assign wd_full   = d3_ff - DB'(wq3_ff) * DB'(etcd_pkg::DAYS_PER_WEEK);

   etcd_recip #(.XW(17), .DIV(etcd_pkg::SECS_PER_HOUR), .QW(5)) u_hr (
      .x (sod3_ff),
      .q (hr_q)
   );

   etcd_recip #(.XW(18), .DIV(etcd_pkg::DAYS_100Y), .QW(3)) u_c100 (
      .x (r400_4_ff),
      .q (q100_raw)
   );

   assign q100_c   = (q100_raw > 3'd3) ? 2'd3 : q100_raw[1:0];
   assign rem_full = sod4_ff - 17'(hr_ff[4]) * 17'(etcd_pkg::SECS_PER_HOUR);

   assign r100_full = r400_5_ff - 18'(q100_5_ff) * 18'(etcd_pkg::DAYS_100Y);

   etcd_recip #(.XW(12), .DIV(etcd_pkg::SECS_PER_MIN), .QW(6)) u_mn (
      .x (rem5_ff),
      .q (mn_q)
   );

   etcd_recip #(.XW(16), .DIV(etcd_pkg::DAYS_4Y), .QW(5)) u_c4 (
      .x (r100_6_ff),
      .q (c4_q)
   );

   assign sec_full = rem6_ff - 12'(mn_ff[6]) * 12'(etcd_pkg::SECS_PER_MIN);
   assign r4_full  = r100_7_ff - 16'(q4_7_ff) * 16'(etcd_pkg::DAYS_4Y);

   etcd_recip #(.XW(11), .DIV(etcd_pkg::DAYS_1Y), .QW(3)) u_c1 (
      .x (r4_8_ff),
      .q (q1_raw)
   );

   assign q1_c    = (q1_raw > 3'd3) ? 2'd3 : q1_raw[1:0];
   assign r1_full = r4_9_ff - 11'(q1_9_ff) * 11'(etcd_pkg::DAYS_1Y);

   // month and day from day of year
   always_comb begin
      logic [3:0] mon;
      logic [8:0] st;
      mon = 4'd12;
      for (int m = 11; m >= 1; m--) begin
         if (r1_10_ff < etcd_pkg::month_start(4'(m)) +
                        ((m >= 2) ? 9'(leap10_ff) : 9'd0)) begin
            mon = 4'(m);
         end
      end
      st = etcd_pkg::month_start(mon - 4'd1) + ((mon >= 4'd3) ? 9'(leap10_ff) : 9'd0);
      out_in              = '0;
      out_in.millis_out   = ms_ff[10];
      out_in.before_epoch = bef_ff[10];
      if (!bef_ff[10]) begin
         out_in.year         = yr_ff[10];
         out_in.month        = mon;
         out_in.day_of_month = 5'(r1_10_ff - st + 9'd1);
         out_in.hour         = hr_ff[10];
         out_in.minute       = mn_ff[10];
         out_in.second       = sec_ff[10];
         out_in.weekday      = wd_ff[10];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec0_ff  <= req_data.epoch_seconds[UB-1:0];
         ms_ff[0] <= req_data.millis_in;
      end
      if (adv[1]) begin
         t1_ff     <= diff_s[UB:0];
         bef_ff[1] <= diff_s[UB+1];
      end
      if (adv[2]) begin
         d2_ff <= day_q;
         t2_ff <= t1_ff;
      end
      if (adv[3]) begin
         sod3_ff   <= sod_full[16:0];
         d3_ff     <= d2_ff;
         q400_3_ff <= c400_q;
         wq3_ff    <= wk_q;
      end
      if (adv[4]) begin
         r400_4_ff <= r400_full[17:0];
         sod4_ff   <= sod3_ff;
         hr_ff[4]  <= hr_q;
         wd_ff[4]  <= wd_full[2:0];
         yr_ff[4]  <= etcd_pkg::YEAR_BASE + 12'(q400_3_ff) * 12'd400;
      end
      if (adv[5]) begin
         r400_5_ff <= r400_4_ff;
         q100_5_ff <= q100_c;
         rem5_ff   <= rem_full[11:0];
         yr_ff[5]  <= yr_ff[4];
      end
      if (adv[6]) begin
         r100_6_ff <= r100_full[15:0];
         q100_6_ff <= q100_5_ff;
         rem6_ff   <= rem5_ff;
         mn_ff[6]  <= mn_q;
         yr_ff[6]  <= yr_ff[5] + 12'(q100_5_ff) * 12'd100;
      end
      if (adv[7]) begin
         r100_7_ff <= r100_6_ff;
         q100_7_ff <= q100_6_ff;
         q4_7_ff   <= c4_q;
         sec_ff[7] <= sec_full[5:0];
         yr_ff[7]  <= yr_ff[6];
      end
      if (adv[8]) begin
         r4_8_ff  <= r4_full[10:0];
         lc8_ff   <= (q4_7_ff != 5'd24) || (q100_7_ff == 2'd3);
         yr_ff[8] <= yr_ff[7] + 12'(q4_7_ff) * 12'd4;
      end
      if (adv[9]) begin
         r4_9_ff  <= r4_8_ff;
         q1_9_ff  <= q1_c;
         lc9_ff   <= lc8_ff;
         yr_ff[9] <= yr_ff[8];
      end
      if (adv[10]) begin
         r1_10_ff  <= r1_full[8:0];
         leap10_ff <= (q1_9_ff == 2'd3) && lc9_ff;
         yr_ff[10] <= yr_ff[9] + 12'(q1_9_ff);
      end
      if (adv[LAST]) begin
         out_ff <= out_in;
      end
      for (int k = 1; k <= 10; k++) begin
         if (adv[k]) begin
            ms_ff[k] <= ms_ff[k-1];
         end
      end
      for (int k = 2; k <= 10; k++) begin
         if (adv[k]) begin
            bef_ff[k] <= bef_ff[k-1];
         end
      end
      for (int k = 5; k <= 10; k++) begin
         if (adv[k]) begin
            hr_ff[k] <= hr_ff[k-1];
            wd_ff[k] <= wd_ff[k-1];
         end
      end
      for (int k = 7; k <= 10; k++) begin
         if (adv[k]) begin
            mn_ff[k] <= mn_ff[k-1];
         end
      end
      for (int k = 8; k <= 10; k++) begin
         if (adv[k]) begin
            sec_ff[k] <= sec_ff[k-1];
         end
      end
   end

endmodule

`default_nettype wire
